// ----- rtl/bit_sliced_counter_bank_assert.svh -----
// assertion helpers for the counter bank checker
`ifndef BIT_SLICED_COUNTER_BANK_ASSERT_SVH
`define BIT_SLICED_COUNTER_BANK_ASSERT_SVH

// consequent checked in the cycle after the antecedent
`define BSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// consequent checked in the same cycle as the antecedent
`define BSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/bsc_pkg.sv -----
package bsc_pkg;

	localparam int LANES = 64;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_SUB   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  word_index;
		logic [63:0] data_word;
		logic [3:0]  slices_to_add;
		logic [7:0]  subtrahend;
		logic [2:0]  slice_select;
	} req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic [63:0] top_slice_word;
	} rsp_t;

endpackage

// ----- rtl/bsc_ram.sv -----
module bsc_ram #(
	parameter int WIDTH = 512,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/bsc_lane.sv -----
module bsc_lane #(
	parameter int SLICES = 8
) (
	input  bsc_pkg::op_t      op,
	input  logic [SLICES-1:0] cur,
	input  logic              data_bit,
	input  logic [SLICES-1:0] add_mask,
	input  logic [SLICES-1:0] sub_val,
	output logic [SLICES-1:0] nxt
);

	import bsc_pkg::*;

	logic [SLICES-1:0] sum;
	logic [SLICES-1:0] diff;

	// carry into a masked slice comes only from lower slices, so a full add
	// followed by a mask matches the half-adder ripple
	assign sum  = cur + SLICES'(data_bit);
	assign diff = cur - sub_val;

	always_comb begin
		unique case (op)
			OP_CLEAR: nxt = '0;
			OP_ADD:   nxt = (sum & add_mask) | (cur & ~add_mask);
			OP_SUB:   nxt = diff;
			OP_READ:  nxt = cur;
		endcase
	end

endmodule

// ----- rtl/bit_sliced_counter_bank.sv -----
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_stall | bsc_pkg::req_t
// rsp     | out       | rsp_valid / rsp_stall | bsc_pkg::rsp_t
//
// an item passes two steps: reading the word's row of all slices from the
// row memory (one read port, one write port), then the 64 counter lanes and
// write-back. after reset a clearing pass writes zero to every row, with
// req_stall high throughout.
// a result waiting on rsp_stall does not block the next request; the
// following result waits in the lane stage until the output register frees.
module bit_sliced_counter_bank #(
	parameter int SLICES = 8,
	parameter int WORDS  = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bsc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bsc_pkg::rsp_t rsp
);

	import bsc_pkg::*;

	localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int ROW_W    = SLICES * LANES;
	localparam logic [AW-1:0] CLR_LAST = AW'(WORDS - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  clr_q;
	req_t           req_q;
	rsp_t           rsp_q;
	logic           rsp_valid_q;

	logic              req_accept;
	logic              req_in_range;
	logic              q_in_range;
	logic              rsp_free;
	logic              exec_write;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic [ROW_W-1:0]  ram_rdata;
	logic [ROW_W-1:0]  row_new;
	logic [SLICES-1:0] add_mask;
	logic [SLICES-1:0] sub_val;
	logic [LANES-1:0]  sel_word;
	rsp_t              rsp_next;

	logic [SLICES-1:0] lane_cur [LANES];
	logic [SLICES-1:0] lane_nxt [LANES];

	assign req_stall    = (state_q != ST_IDLE);
	assign req_accept   = req_valid && !req_stall;
	assign req_in_range = (32'(req.word_index) < WORDS);
	assign q_in_range   = (32'(req_q.word_index) < WORDS);
	assign rsp_free     = !rsp_valid_q || !rsp_stall;

	assign exec_write = (state_q == ST_EXEC) && rsp_free && q_in_range
		&& (req_q.op != OP_READ);
	assign ram_we    = (state_q == ST_CLEAR) || exec_write;
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : AW'(req_q.word_index);
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : row_new;

	bsc_ram #(
		.WIDTH(ROW_W),
		.DEPTH(WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (req_accept && req_in_range),
		.raddr (AW'(req.word_index)),
		.rdata (ram_rdata)
	);

	always_comb begin
		for (int s = 0; s < SLICES; s++) begin
			add_mask[s] = (32'(req_q.slices_to_add) > s);
		end
	end

	// subtrahend bits above the counter width drop out, missing ones are zero
	assign sub_val = SLICES'(req_q.subtrahend);

	// row holds slice s of lane l at bit s*LANES+l
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		for (genvar s = 0; s < SLICES; s++) begin : g_bit
			assign lane_cur[l][s]        = ram_rdata[s*LANES+l];
			assign row_new[s*LANES+l]    = lane_nxt[l][s];
		end

		bsc_lane #(
			.SLICES(SLICES)
		) u_lane (
			.op       (req_q.op),
			.cur      (lane_cur[l]),
			.data_bit (req_q.data_word[l]),
			.add_mask (add_mask),
			.sub_val  (sub_val),
			.nxt      (lane_nxt[l])
		);
	end

	// merge: pick the read slice and the top slice back out of the row
	always_comb begin
		sel_word = '0;
		for (int s = 0; s < SLICES; s++) begin
			if (32'(req_q.slice_select) == s) begin
				sel_word = ram_rdata[s*LANES +: LANES];
			end
		end
	end

	always_comb begin
		rsp_next = '0;
		if (q_in_range) begin
			rsp_next.read_data      = (req_q.op == OP_READ) ? sel_word : '0;
			rsp_next.top_slice_word = row_new[(SLICES-1)*LANES +: LANES];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_EXEC) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req_accept) begin
						req_q   <= req;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (rsp_free) begin
						rsp_q   <= rsp_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/bsc_checker.sv -----
`include "bit_sliced_counter_bank_assert.svh"

module bsc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input bsc_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input bsc_pkg::rsp_t rsp
);

	import bsc_pkg::*;

	// stalled result holds
	`BSC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// only one transaction in flight
	`BSC_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && !req_stall, req_stall)

	// a free output takes the result in the cycle after the lane stage
	`BSC_ASSERT_NEXT(a_result_due, clk, arst_n, (req_valid && !req_stall) ##1 !rsp_stall, rsp_valid)

	// a new result only follows a transaction in the lane stage
	`BSC_ASSERT_SAME(a_no_phantom, clk, arst_n, $rose(rsp_valid), $past(req_stall))

endmodule

bind bit_sliced_counter_bank bsc_checker u_bsc_checker (.*);
